### rtl/lrqlc_pkg.sv
// Shared types and constants for the loss and round-trip quality level controller.
package lrqlc_pkg;

  typedef enum logic [1:0] {
    LVL_LOW    = 2'd0,
    LVL_MED    = 2'd1,
    LVL_HIGH   = 2'd2,
    LVL_CUSTOM = 2'd3
  } level_t;

  typedef enum logic [2:0] {
    REG_ADAPTIVE_ENABLE   = 3'd0,
    REG_START_LEVEL       = 3'd1,
    REG_LOSS_CRITICAL     = 3'd2,
    REG_LOSS_HIGH         = 3'd3,
    REG_LOSS_LOW          = 3'd4,
    REG_RTT_CRITICAL      = 3'd5,
    REG_RTT_HIGH          = 3'd6,
    REG_DOWNGRADE_COOLDWN = 3'd7
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 160;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TOTAL_W = COUNT_W + 1;
  localparam int unsigned TENTH_W = 10;
  localparam int unsigned PROD_W  = TOTAL_W + TENTH_W;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned MS_W    = 16;

  localparam logic [TENTH_W-1:0] TENTHS_PER_UNIT = 10'd1000;

  localparam logic [MS_W-1:0] UPGRADE_COOLDOWN_MS = 16'd5000;
  localparam logic [MS_W-1:0] UPGRADE_SUSTAIN_MS  = 16'd10000;
  localparam level_t          TOP_LEVEL           = LVL_HIGH;

  localparam logic           RST_ADAPTIVE_ENABLE = 1'b1;
  localparam level_t         RST_START_LEVEL     = LVL_MED;
  localparam logic [TENTH_W-1:0] RST_LOSS_CRITICAL = 10'd150;
  localparam logic [TENTH_W-1:0] RST_LOSS_HIGH     = 10'd50;
  localparam logic [TENTH_W-1:0] RST_LOSS_LOW      = 10'd10;
  localparam logic [MS_W-1:0] RST_RTT_CRITICAL     = 16'd800;
  localparam logic [MS_W-1:0] RST_RTT_HIGH         = 16'd400;
  localparam logic [MS_W-1:0] RST_DOWNGRADE_CD     = 16'd2000;

endpackage

### rtl/loss_rtt_quality_level_control.sv
// Quality level controller driven by loss and round-trip statistics reports.
//
// Usage:
//   s_* stream carries one statistics report per transaction; tdata packs
//   received_count, lost_count, round_trip_ms and timestamp_ms from bit 0 up.
//   m_* stream returns one result per report: level_now and level_changed.
//   wr_en / wr_index / wr_data write the eight thresholds and mode registers;
//   writing the starting level also loads the current level. Write only while idle.
// Path: a report passes the input register, the product register and the
//   result register in that order before its result is valid.
// Throughput: one report per cycle while m_tready is high; each of the three
//   stages loads when the next is free; the last stage updates level and timestamps.
// Reset: rst clears the pipeline valids, loads the register reset values,
//   sets the level to medium and clears all timestamps and low-loss tracking.
// Stall: when m_tready is low the result holds and the earlier stages keep
//   filling; s_tready falls once every stage holds a report.
module loss_rtt_quality_level_control (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // received_count[31:0], lost_count[63:32], round_trip_ms[95:64],
  // timestamp_ms[159:96]
  input  logic [lrqlc_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // level_now[1:0], level_changed[2], zero[7:3]
  output logic [lrqlc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                          wr_en,
  input  logic [lrqlc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [lrqlc_pkg::CFG_DATA_W-1:0]  wr_data
);
  import lrqlc_pkg::*;

  // configuration
  logic                adaptive_enable;
  logic [TENTH_W-1:0]  loss_critical_tenths;
  logic [TENTH_W-1:0]  loss_high_tenths;
  logic [TENTH_W-1:0]  loss_low_tenths;
  logic [MS_W-1:0]     rtt_critical_ms;
  logic [MS_W-1:0]     rtt_high_ms;
  logic [MS_W-1:0]     downgrade_cooldown_ms;

  // state
  level_t              quality_level;
  logic [TIME_W-1:0]   last_down_time;
  logic [TIME_W-1:0]   last_up_time;
  logic [TIME_W-1:0]   low_loss_start;
  logic                low_loss_valid;

  // stage 1: input register
  logic                in_valid;
  logic [COUNT_W-1:0]  in_rx;
  logic [COUNT_W-1:0]  in_lost;
  logic [COUNT_W-1:0]  in_rtt;
  logic [TIME_W-1:0]   in_now;

  // stage 2: products and rtt compares
  logic                pr_valid;
  logic [PROD_W-1:0]   pr_num;
  logic [PROD_W-1:0]   pr_crit;
  logic [PROD_W-1:0]   pr_high;
  logic [PROD_W-1:0]   pr_low;
  logic                pr_rtt_gt_crit;
  logic                pr_rtt_gt_high;
  logic [TIME_W-1:0]   pr_now;

  // stage 3: result
  level_t              res_level;
  logic                res_changed;

  logic out_ld, pr_ld, in_ld;

  assign out_ld   = !m_tvalid || m_tready;
  assign pr_ld    = !pr_valid || out_ld;
  assign in_ld    = !in_valid || pr_ld;
  assign s_tready = in_ld;

  assign m_tdata = {{(OUT_DATA_W-3){1'b0}}, res_changed, res_level};

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ld) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ld && s_tvalid) begin
      in_rx   <= s_tdata[31:0];
      in_lost <= s_tdata[63:32];
      in_rtt  <= s_tdata[95:64];
      in_now  <= s_tdata[159:96];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [TOTAL_W-1:0] total_raw;
  logic [TOTAL_W-1:0] total;

  always_comb begin
    total_raw = {1'b0, in_rx} + {1'b0, in_lost};
    // zero total: lost is zero too, so any nonzero divisor gives zero loss
    total = (total_raw == '0) ? TOTAL_W'(1) : total_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (pr_ld) begin
      pr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_ld && in_valid) begin
      pr_num  <= PROD_W'(in_lost) * PROD_W'(TENTHS_PER_UNIT);
      pr_crit <= PROD_W'(loss_critical_tenths) * PROD_W'(total);
      pr_high <= PROD_W'(loss_high_tenths) * PROD_W'(total);
      pr_low  <= PROD_W'(loss_low_tenths) * PROD_W'(total);
      pr_rtt_gt_crit <= in_rtt > COUNT_W'(rtt_critical_ms);
      pr_rtt_gt_high <= in_rtt > COUNT_W'(rtt_high_ms);
      pr_now  <= in_now;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic              adapt;
  logic              cd_zero;
  logic              down_ok;
  logic              down_ok2;
  level_t            lvl1, lvl2, lvl3;
  logic              valid1, valid3;
  logic [TIME_W-1:0] start1;
  logic              took1, took2;
  logic              up_go;
  logic [TIME_W-1:0] since_down, since_up, since_start;

  always_comb begin
    adapt       = adaptive_enable && (quality_level != LVL_CUSTOM);
    cd_zero     = (downgrade_cooldown_ms == '0);
    since_down  = pr_now - last_down_time;
    since_up    = pr_now - last_up_time;
    down_ok     = since_down >= TIME_W'(downgrade_cooldown_ms);

    lvl1   = quality_level;
    valid1 = low_loss_valid;
    start1 = low_loss_start;
    took1  = 1'b0;
    priority if (pr_num > pr_crit) begin
      if (quality_level != LVL_LOW && down_ok) begin
        lvl1   = LVL_LOW;
        took1  = 1'b1;
        valid1 = 1'b0;
      end
    end else if (pr_num > pr_high) begin
      if (quality_level != LVL_LOW && down_ok) begin
        lvl1   = level_t'(quality_level - 2'd1);
        took1  = 1'b1;
        valid1 = 1'b0;
      end
    end else if (pr_num < pr_low) begin
      if (!low_loss_valid) begin
        valid1 = 1'b1;
        start1 = pr_now;
      end
    end else begin
      valid1 = 1'b0;
    end

    // a downgrade just taken leaves zero elapsed time
    down_ok2 = took1 ? cd_zero : down_ok;
    lvl2  = lvl1;
    took2 = took1;
    priority if (pr_rtt_gt_crit && lvl1 > LVL_LOW) begin
      if (down_ok2) begin
        lvl2  = LVL_LOW;
        took2 = 1'b1;
      end
    end else if (pr_rtt_gt_high && lvl1 > LVL_MED) begin
      if (down_ok2) begin
        lvl2  = LVL_MED;
        took2 = 1'b1;
      end
    end else begin
      lvl2 = lvl1;
    end

    since_start = pr_now - start1;
    up_go = valid1 && (since_start >= TIME_W'(UPGRADE_SUSTAIN_MS)) &&
            (lvl2 < TOP_LEVEL) && (since_up >= TIME_W'(UPGRADE_COOLDOWN_MS)) &&
            !pr_rtt_gt_high;
    lvl3   = up_go ? level_t'(lvl2 + 2'd1) : lvl2;
    valid3 = up_go ? 1'b0 : valid1;
  end

  logic step;
  assign step = pr_valid && out_ld && adapt;

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_enable       <= RST_ADAPTIVE_ENABLE;
      loss_critical_tenths  <= RST_LOSS_CRITICAL;
      loss_high_tenths      <= RST_LOSS_HIGH;
      loss_low_tenths       <= RST_LOSS_LOW;
      rtt_critical_ms       <= RST_RTT_CRITICAL;
      rtt_high_ms           <= RST_RTT_HIGH;
      downgrade_cooldown_ms <= RST_DOWNGRADE_CD;
      quality_level         <= RST_START_LEVEL;
      last_down_time        <= '0;
      last_up_time          <= '0;
      low_loss_start        <= '0;
      low_loss_valid        <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_ADAPTIVE_ENABLE:   adaptive_enable <= wr_data[0];
        REG_START_LEVEL:       quality_level   <= level_t'(wr_data[1:0]);
        REG_LOSS_CRITICAL:     loss_critical_tenths  <= wr_data[TENTH_W-1:0];
        REG_LOSS_HIGH:         loss_high_tenths      <= wr_data[TENTH_W-1:0];
        REG_LOSS_LOW:          loss_low_tenths       <= wr_data[TENTH_W-1:0];
        REG_RTT_CRITICAL:      rtt_critical_ms       <= wr_data;
        REG_RTT_HIGH:          rtt_high_ms           <= wr_data;
        REG_DOWNGRADE_COOLDWN: downgrade_cooldown_ms <= wr_data;
        default: ;
      endcase
    end else if (step) begin
      quality_level  <= lvl3;
      low_loss_valid <= valid3;
      low_loss_start <= start1;
      if (took2) begin
        last_down_time <= pr_now;
      end
      if (up_go) begin
        last_up_time <= pr_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ld) begin
      m_tvalid <= pr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_valid && out_ld) begin
      res_level   <= adapt ? lvl3 : quality_level;
      res_changed <= adapt && (lvl3 != quality_level);
    end
  end

endmodule
